### rtl/core/aas3d_pkg.sv
// aas3d_pkg: shared widths, register indexes and stream word types
// for the 3D avoidance step block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aas3d_pkg;
  localparam int CW = 24;
  localparam int RW = 23;
  localparam int SW = 16;
  localparam int DW = CW + 1;
  localparam int QW = 2 * DW + 2;
  localparam int NW = DW + 1;
  localparam int PW = SW + DW;
  localparam int IW = 3;

  typedef enum logic [IW-1:0] {
    REG_GOAL_X = 3'd0, REG_GOAL_Y = 3'd1, REG_GOAL_Z = 3'd2,
    REG_START_X = 3'd3, REG_START_Y = 3'd4, REG_START_Z = 3'd5,
    REG_SPEED = 3'd6, REG_RADIUS = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [CW-1:0] other_x;
    logic signed [CW-1:0] other_y;
    logic signed [CW-1:0] other_z;
    logic [RW-1:0]        other_radius;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] new_x;
    logic signed [CW-1:0] new_y;
    logic signed [CW-1:0] new_z;
    logic                 avoided;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] data;
  } cfg_word_t;
endpackage
`default_nettype wire

### rtl/core/aas3d_if.sv
// aas3d_if: valid/ready stream interfaces for input, output and config words.
// Depends on aas3d_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface aas3d_in_if;
  logic valid;
  logic ready;
  aas3d_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aas3d_out_if;
  logic valid;
  logic ready;
  aas3d_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aas3d_cfg_if;
  logic valid;
  logic ready;
  aas3d_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/aas3d_sqacc.sv
// aas3d_sqacc: bit-serial squarer-accumulator, one multiplier bit per cycle.
// Accumulates a*a into a wide sum. Depends on aas3d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aas3d_sqacc (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   clear_i,
  input  wire logic                   load_i,
  input  wire logic [aas3d_pkg::DW-1:0] mag_i,
  output logic                        busy_o,
  output logic [aas3d_pkg::QW-1:0]    acc_o
);
  localparam int CNW = $clog2(aas3d_pkg::DW + 1);
  logic [aas3d_pkg::DW-1:0] m_q;
  logic [aas3d_pkg::QW-1:0] sh_q, acc_q;
  logic [CNW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CNW'(aas3d_pkg::DW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      acc_q <= '0;
    end else if (cnt_q != '0 && m_q[0]) begin
      acc_q <= acc_q + sh_q;
    end
    if (load_i) begin
      m_q  <= mag_i;
      sh_q <= aas3d_pkg::QW'(mag_i);
    end else if (cnt_q != '0) begin
      m_q  <= m_q >> 1;
      sh_q <= sh_q << 1;
    end
  end

  assign busy_o = cnt_q != '0 || load_i;
  assign acc_o  = acc_q;
endmodule
`default_nettype wire

### rtl/core/aas3d_sqrt.sv
// aas3d_sqrt: restoring square root, one result bit per cycle.
// Depends on aas3d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aas3d_sqrt (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [aas3d_pkg::QW-1:0] s_i,
  output logic                        busy_o,
  output logic [aas3d_pkg::NW-1:0]    root_o
);
  localparam int CNW = $clog2(aas3d_pkg::NW + 1);
  logic [aas3d_pkg::QW-1:0] s_q;
  logic [aas3d_pkg::NW+1:0] rem_q;
  logic [aas3d_pkg::NW-1:0] root_q;
  logic [CNW-1:0] cnt_q;
  logic [aas3d_pkg::NW+1:0] rem_sh, trial;

  assign rem_sh = {rem_q[aas3d_pkg::NW-1:0], s_q[aas3d_pkg::QW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNW'(aas3d_pkg::NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q    <= s_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      s_q <= s_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[aas3d_pkg::NW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[aas3d_pkg::NW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = cnt_q != '0 || start_i;
  assign root_o = root_q;
endmodule
`default_nettype wire

### rtl/core/aas3d_div.sv
// aas3d_div: bit-serial product and restoring divide, floor(speed*m/norm).
// Shift-add multiply then one quotient bit per cycle. Depends on aas3d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aas3d_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [aas3d_pkg::SW-1:0]  speed_i,
  input  wire logic [aas3d_pkg::DW-1:0]  mag_i,
  input  wire logic [aas3d_pkg::NW-1:0]  norm_i,
  output logic                         busy_o,
  output logic [aas3d_pkg::PW-1:0]     quo_o
);
  localparam int MC  = aas3d_pkg::SW;
  localparam int DC  = aas3d_pkg::PW;
  localparam int CNW = $clog2(MC + DC + 1);
  logic [CNW-1:0] cnt_q;
  logic [aas3d_pkg::SW-1:0] m_q;
  logic [aas3d_pkg::PW-1:0] p_q, sh_q, n_q, quo_q;
  logic [aas3d_pkg::NW-1:0] d_q;
  logic [aas3d_pkg::NW:0] rem_q, rem_sh;
  logic mul_ph;

  assign mul_ph = cnt_q > CNW'(DC);
  assign rem_sh = {rem_q[aas3d_pkg::NW-1:0], n_q[aas3d_pkg::PW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNW'(MC + DC);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q   <= speed_i;
      sh_q  <= aas3d_pkg::PW'(mag_i);
      p_q   <= '0;
      d_q   <= norm_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      if (mul_ph) begin
        if (m_q[0]) p_q <= p_q + sh_q;
        m_q  <= m_q >> 1;
        sh_q <= sh_q << 1;
        if (cnt_q == CNW'(DC + 1)) n_q <= m_q[0] ? p_q + sh_q : p_q;
      end else begin
        n_q <= n_q << 1;
        if (rem_sh >= {1'b0, d_q}) begin
          rem_q <= rem_sh - {1'b0, d_q};
          quo_q <= {quo_q[aas3d_pkg::PW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[aas3d_pkg::PW-2:0], 1'b0};
        end
      end
    end
  end

  assign busy_o = cnt_q != '0 || start_i;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

### rtl/core/agent_avoidance_step_3d.sv
// agent_avoidance_step_3d: top level, sequencer, position state, config.
// Depends on aas3d_pkg, aas3d_if, aas3d_sqacc, aas3d_sqrt, aas3d_div.
//
// Usage: in_i carries other agent words (x, y, z, radius); out_o returns one
// word per input: new position and the avoided flag. cfg_i writes registers
// by index (goal xyz, start xyz, speed, radius); a start write also loads
// that coordinate of the position. Indexes beyond 7 are ignored.
// One word is processed at a time. The sequencer squares the three distance
// components on the bit-serial squarer, then the radius sum, compares, squares
// the three direction components, takes the square root, runs the three serial
// multiply-divides, updates the position and registers the result. When the
// direction has zero length the divides and the update are skipped. The next
// word is accepted once the sequencer is back in idle. The result sits in an
// output register; a stalled receiver holds it, and a following result waits
// in the sequencer until it is accepted. Reset loads position and goal to
// zero, speed 512, radius 3840. Config is taken only while idle.
`timescale 1ns / 1ps
`default_nettype none
module agent_avoidance_step_3d (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aas3d_in_if.sink    in_i,
  aas3d_out_if.source out_o,
  aas3d_cfg_if.sink   cfg_i
);
  localparam int CW = aas3d_pkg::CW;
  localparam int DW = aas3d_pkg::DW;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_DSQ = 9'b000000010, S_RSQ = 9'b000000100,
    S_VSQ  = 9'b000001000, S_SQRT = 9'b000010000, S_DIV = 9'b000100000,
    S_UPD  = 9'b001000000, S_OUT = 9'b010000000, S_WAIT = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic signed [CW-1:0] goal_q [3];
  logic signed [CW-1:0] pos_q [3];
  logic [aas3d_pkg::SW-1:0] speed_q;
  logic [aas3d_pkg::RW-1:0] rad_q;
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] v_q [3];
  logic [aas3d_pkg::RW:0] rsum_q;
  logic [aas3d_pkg::QW-1:0] dsq_q;
  logic avoid_q;
  logic [1:0] k_q;
  logic started_q;
  logic [aas3d_pkg::PW-1:0] quo_q [3];
  logic [aas3d_pkg::NW-1:0] norm_q;
  aas3d_pkg::out_word_t out_q;
  logic out_v_q;

  logic sq_clear, sq_load, sq_busy;
  logic [DW-1:0] sq_mag;
  logic [aas3d_pkg::QW-1:0] sq_acc;
  logic rt_start, rt_busy;
  logic [aas3d_pkg::NW-1:0] rt_root;
  logic dv_start, dv_busy;
  logic [aas3d_pkg::PW-1:0] dv_quo;
  logic in_fire, cfg_fire;

  function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] v);
    mag_f = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic signed [CW-1:0] sat_f(input logic signed [CW-1:0] p,
      input logic neg, input logic [aas3d_pkg::PW-1:0] q);
    logic signed [aas3d_pkg::PW+1:0] r;
    r = neg ? (aas3d_pkg::PW+2)'(p) - $signed({2'b00, q})
            : (aas3d_pkg::PW+2)'(p) + $signed({2'b00, q});
    if (r > $signed((aas3d_pkg::PW+2)'({1'b0, {(CW-1){1'b1}}})))
      sat_f = {1'b0, {(CW-1){1'b1}}};
    else if (r < -((aas3d_pkg::PW+2)'(1) <<< (CW-1))) sat_f = {1'b1, {(CW-1){1'b0}}};
    else sat_f = r[CW-1:0];
  endfunction

  assign in_i.ready  = state_q == S_IDLE;
  assign cfg_i.ready = state_q == S_IDLE;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  always_comb begin
    unique case (k_q)
      2'd0:    sq_mag = state_q == S_VSQ ? mag_f(v_q[0]) : mag_f(d_q[0]);
      2'd1:    sq_mag = state_q == S_VSQ ? mag_f(v_q[1]) : mag_f(d_q[1]);
      default: sq_mag = state_q == S_VSQ ? mag_f(v_q[2]) : mag_f(d_q[2]);
    endcase
    if (state_q == S_RSQ) sq_mag = DW'(rsum_q);
  end

  assign sq_clear = (state_q == S_IDLE) || (state_q == S_RSQ && !started_q)
                 || (state_q == S_VSQ && !started_q && k_q == 2'd0);
  assign sq_load  = !started_q && (state_q == S_DSQ || state_q == S_RSQ
                 || state_q == S_VSQ);
  assign rt_start = state_q == S_SQRT && !started_q;
  assign dv_start = state_q == S_DIV && !started_q;

  aas3d_sqacc u_sqacc (.clk_i, .rst_ni, .clear_i(sq_clear), .load_i(sq_load),
    .mag_i(sq_mag), .busy_o(sq_busy), .acc_o(sq_acc));
  aas3d_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(rt_start), .s_i(sq_acc),
    .busy_o(rt_busy), .root_o(rt_root));
  aas3d_div u_div (.clk_i, .rst_ni, .start_i(dv_start), .speed_i(speed_q),
    .mag_i(k_q == 2'd0 ? mag_f(v_q[0]) : k_q == 2'd1 ? mag_f(v_q[1]) : mag_f(v_q[2])),
    .norm_i(norm_q), .busy_o(dv_busy), .quo_o(dv_quo));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_DSQ;
      S_DSQ:  if (started_q && !sq_busy && k_q == 2'd2) state_d = S_RSQ;
      S_RSQ:  if (started_q && !sq_busy) state_d = S_WAIT;
      S_WAIT: state_d = S_VSQ;
      S_VSQ:  if (started_q && !sq_busy && k_q == 2'd2) state_d = S_SQRT;
      S_SQRT: if (started_q && !rt_busy) state_d = rt_root == '0 ? S_OUT : S_DIV;
      S_DIV:  if (started_q && !dv_busy && k_q == 2'd2) state_d = S_UPD;
      S_UPD:  state_d = S_OUT;
      S_OUT:  if (!out_v_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      k_q       <= '0;
      out_v_q   <= 1'b0;
      speed_q   <= aas3d_pkg::SW'(512);
      rad_q     <= aas3d_pkg::RW'(3840);
      for (int i = 0; i < 3; i++) begin
        goal_q[i] <= '0;
        pos_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        started_q <= 1'b0;
        k_q <= '0;
      end else if ((state_q == S_DSQ || state_q == S_VSQ || state_q == S_RSQ)) begin
        if (!started_q) started_q <= 1'b1;
        else if (!sq_busy) begin
          started_q <= 1'b0;
          k_q <= k_q + 1'b1;
        end
      end else if (state_q == S_DIV) begin
        if (!started_q) started_q <= 1'b1;
        else if (!dv_busy) begin
          started_q <= 1'b0;
          k_q <= k_q + 1'b1;
        end
      end else if (state_q == S_SQRT) begin
        started_q <= 1'b1;
      end
      if (state_q == S_OUT && state_d == S_IDLE) out_v_q <= 1'b1;
      else if (out_v_q && out_o.ready) out_v_q <= 1'b0;
      if (state_q == S_UPD) begin
        for (int i = 0; i < 3; i++) pos_q[i] <= sat_f(pos_q[i], v_q[i][DW-1], quo_q[i]);
      end
      if (cfg_fire && !cfg_i.data.index[3]) begin
        unique case (aas3d_pkg::reg_idx_e'(cfg_i.data.index[2:0]))
          aas3d_pkg::REG_GOAL_X:  goal_q[0] <= cfg_i.data.data[CW-1:0];
          aas3d_pkg::REG_GOAL_Y:  goal_q[1] <= cfg_i.data.data[CW-1:0];
          aas3d_pkg::REG_GOAL_Z:  goal_q[2] <= cfg_i.data.data[CW-1:0];
          aas3d_pkg::REG_START_X: pos_q[0]  <= cfg_i.data.data[CW-1:0];
          aas3d_pkg::REG_START_Y: pos_q[1]  <= cfg_i.data.data[CW-1:0];
          aas3d_pkg::REG_START_Z: pos_q[2]  <= cfg_i.data.data[CW-1:0];
          aas3d_pkg::REG_SPEED:   speed_q   <= cfg_i.data.data[aas3d_pkg::SW-1:0];
          aas3d_pkg::REG_RADIUS:  rad_q     <= cfg_i.data.data[aas3d_pkg::RW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      d_q[0] <= DW'(in_i.data.other_x) - DW'(pos_q[0]);
      d_q[1] <= DW'(in_i.data.other_y) - DW'(pos_q[1]);
      d_q[2] <= DW'(in_i.data.other_z) - DW'(pos_q[2]);
      rsum_q <= {1'b0, rad_q} + {1'b0, in_i.data.other_radius};
    end
    if (state_q == S_RSQ && !started_q) dsq_q <= sq_acc;
    if (state_q == S_WAIT) begin
      avoid_q <= dsq_q < sq_acc;
      if (dsq_q < sq_acc) begin
        v_q[0] <= -d_q[1];
        v_q[1] <= d_q[0];
        v_q[2] <= '0;
      end else begin
        for (int i = 0; i < 3; i++) v_q[i] <= DW'(goal_q[i]) - DW'(pos_q[i]);
      end
    end
    if (state_q == S_SQRT && started_q && !rt_busy) norm_q <= rt_root;
    if (state_q == S_DIV && started_q && !dv_busy) quo_q[k_q] <= dv_quo;
    if (state_q == S_OUT && state_d == S_IDLE) begin
      out_q.new_x   <= pos_q[0];
      out_q.new_y   <= pos_q[1];
      out_q.new_z   <= pos_q[2];
      out_q.avoided <= avoid_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |=> out_v_q) else $error("result dropped");
endmodule
`default_nettype wire
